// ===== design/image_orientation_transform_macros.svh =====
// Assertion macros used by the image orientation transform top level.
`ifndef IMAGE_ORIENTATION_TRANSFORM_MACROS_SVH
`define IMAGE_ORIENTATION_TRANSFORM_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define IOT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a condition at every clock edge outside reset.
`define IOT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// ===== design/iot_pkg.sv =====
// Package with the types, sizes and codes of the image orientation transform.
`timescale 1ns / 1ps

package iot_pkg;

    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WIDTH  = 256;
    localparam int DEPTH      = MAX_HEIGHT * MAX_WIDTH;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PIX_W   = 24;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Transform modes.
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_HFLIP = 2'd1;
    localparam logic [1:0] MODE_VFLIP = 2'd2;
    localparam logic [1:0] MODE_ROT   = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;

    // Item functions.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_word;

    typedef struct packed {
        logic       ready_res;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_pixel;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== design/iot_frame_store.sv =====
// Frame store memory: one write and one read port, registered read data.
`timescale 1ns / 1ps

module iot_frame_store
    import iot_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_req         i_req,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // A read and a write to the same entry in one cycle return the old word.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/image_orientation_transform.sv =====
// Top level of the image orientation transform frame store.
`timescale 1ns / 1ps
`include "image_orientation_transform_macros.svh"

// Usage
// A word is accepted on a rising edge with i_start high and o_busy low.
// Load words (func = 0) write the next source pixel in raster order; fetch
// words (func = 1) return the next pixel of the transformed image.
// o_busy stays low: one word is taken every cycle, since each word needs a
// single access to the one write and one read port of the frame store.
// A fetch word gives its result on o_res with o_res_valid high once it
// has passed the address and memory read registers; the pipeline is
// address, memory read, output. A load word gives no result. Results are
// shown for exactly one cycle and cannot be held off, so the block never
// stalls.
// Before a full frame is stored a fetch returns ready_res low and zero
// colour. last_pixel marks the final pixel of the output image.
// Configuration (mode, height, width) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data while no word is in flight; dimensions are
// clamped to 1..256 when written.
// Reset clears the load count, the frame flag, the fetch position and the
// registers; the frame store itself is not cleared.

module image_orientation_transform
    import iot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_in_word             i_in,
    output logic                 o_res_valid,
    output t_out_word            o_res
);

    function automatic logic [HDIM_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
        logic [HDIM_W-1:0] res;
        if (v == '0) begin
            res = HDIM_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            res = HDIM_W'(MAX_HEIGHT);
        end else begin
            res = HDIM_W'(v);
        end
        return res;
    endfunction

    function automatic logic [WDIM_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
        logic [WDIM_W-1:0] res;
        if (v == '0) begin
            res = WDIM_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            res = WDIM_W'(MAX_WIDTH);
        end else begin
            res = WDIM_W'(v);
        end
        return res;
    endfunction

    localparam int DIM_W = (HDIM_W > WDIM_W) ? HDIM_W : WDIM_W;
    localparam int TOT_W = HDIM_W + WDIM_W;
    localparam int PROD_W = ROW_W + WDIM_W + 1;

    // Configuration registers.
    logic [1:0]        r_mode;
    logic [HDIM_W-1:0] r_h;
    logic [WDIM_W-1:0] r_w;

    // Load and fetch state.
    logic [CNT_W-1:0] r_load_count, n_load_count;
    logic             r_frame_complete, n_frame_complete;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [COL_W-1:0] r_out_col, n_out_col;

    // Address stage.
    logic             r_s1_valid, r_s1_ready, r_s1_last;
    logic [ROW_W-1:0] r_s1_sr;
    logic [COL_W-1:0] r_s1_sc;

    // Memory read stage.
    logic r_s2_valid, r_s2_ready, r_s2_last;

    logic w_accept, w_load, w_fetch;
    logic [TOT_W-1:0] w_total;
    logic             w_restart;
    logic [CNT_W-1:0] w_load_base;
    logic [DIM_W-1:0] w_orows, w_ocols;
    logic             w_wrap;
    logic [ROW_W-1:0] w_row, w_sr, w_hm1;
    logic [COL_W-1:0] w_col, w_sc, w_wm1;
    logic [DIM_W:0]   w_col_inc, w_row_inc;
    logic             w_col_end, w_row_end;
    logic [PROD_W-1:0] w_addr_sum;
    logic [PIX_W-1:0] w_rdata;
    t_mem_req         w_req;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_load   = w_accept && (i_in.func == FUNC_LOAD);
    assign w_fetch  = w_accept && (i_in.func == FUNC_FETCH);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COPY;
            r_h    <= HDIM_W'(MAX_HEIGHT);
            r_w    <= WDIM_W'(MAX_WIDTH);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode <= i_cfg_data[1:0];
                CFG_HEIGHT: r_h    <= clamp_h(i_cfg_data);
                CFG_WIDTH:  r_w    <= clamp_w(i_cfg_data);
                default:    ;
            endcase
        end
    end

    // Load path: a load after a complete frame, or past the current pixel
    // count, starts a new frame at pixel zero.
    assign w_total     = TOT_W'(r_h) * TOT_W'(r_w);
    assign w_restart   = r_frame_complete || (TOT_W'(r_load_count) >= w_total);
    assign w_load_base = w_restart ? '0 : r_load_count;

    // Fetch path: output size, wrap of a stale position and source coordinates.
    assign w_orows = (r_mode == MODE_ROT) ? DIM_W'(r_w) : DIM_W'(r_h);
    assign w_ocols = (r_mode == MODE_ROT) ? DIM_W'(r_h) : DIM_W'(r_w);
    assign w_wrap  = (DIM_W'(r_out_row) >= w_orows) || (DIM_W'(r_out_col) >= w_ocols);
    assign w_row   = w_wrap ? '0 : r_out_row;
    assign w_col   = w_wrap ? '0 : r_out_col;
    assign w_hm1   = ROW_W'(r_h - HDIM_W'(1));
    assign w_wm1   = COL_W'(r_w - WDIM_W'(1));

    always_comb begin
        case (r_mode)
            MODE_HFLIP: begin
                w_sr = w_row;
                w_sc = w_wm1 - w_col;
            end
            MODE_VFLIP: begin
                w_sr = w_hm1 - w_row;
                w_sc = w_col;
            end
            MODE_ROT: begin
                w_sr = w_hm1 - ROW_W'(w_col);
                w_sc = COL_W'(w_row);
            end
            default: begin
                w_sr = w_row;
                w_sc = w_col;
            end
        endcase
    end

    assign w_col_inc = (DIM_W + 1)'(w_col) + (DIM_W + 1)'(1);
    assign w_row_inc = (DIM_W + 1)'(w_row) + (DIM_W + 1)'(1);
    assign w_col_end = w_col_inc >= (DIM_W + 1)'(w_ocols);
    assign w_row_end = w_row_inc >= (DIM_W + 1)'(w_orows);

    always_comb begin
        n_load_count     = r_load_count;
        n_frame_complete = r_frame_complete;
        n_out_row        = r_out_row;
        n_out_col        = r_out_col;
        if (w_load) begin
            n_load_count     = w_load_base + CNT_W'(1);
            n_frame_complete = TOT_W'(n_load_count) >= w_total;
            if (w_restart) begin
                n_out_row = '0;
                n_out_col = '0;
            end
        end else if (w_fetch && r_frame_complete) begin
            if (w_col_end) begin
                n_out_col = '0;
                n_out_row = w_row_end ? '0 : ROW_W'(w_row_inc);
            end else begin
                n_out_col = COL_W'(w_col_inc);
                n_out_row = w_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count     <= '0;
            r_frame_complete <= 1'b0;
            r_out_row        <= '0;
            r_out_col        <= '0;
            r_s1_valid       <= 1'b0;
            r_s2_valid       <= 1'b0;
        end else begin
            r_load_count     <= n_load_count;
            r_frame_complete <= n_frame_complete;
            r_out_row        <= n_out_row;
            r_out_col        <= n_out_col;
            r_s1_valid       <= w_fetch;
            r_s2_valid       <= r_s1_valid;
        end
    end

    // Payload of the pipeline stages.
    always_ff @(posedge i_clk) begin
        r_s1_ready <= r_frame_complete;
        r_s1_last  <= r_frame_complete && w_col_end && w_row_end;
        r_s1_sr    <= w_sr;
        r_s1_sc    <= w_sc;
        r_s2_ready <= r_s1_ready;
        r_s2_last  <= r_s1_last;
    end

    // Source address is row times width plus column.
    assign w_addr_sum = PROD_W'(r_s1_sr) * PROD_W'(r_w) + PROD_W'(r_s1_sc);

    assign w_req.we    = w_load;
    assign w_req.waddr = w_load_base[ADDR_W-1:0];
    assign w_req.wdata = {i_in.red_in, i_in.green_in, i_in.blue_in};
    assign w_req.re    = r_s1_valid && r_s1_ready;
    assign w_req.raddr = w_addr_sum[ADDR_W-1:0];

    iot_frame_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign o_res_valid     = r_s2_valid;
    assign o_res.ready_res = r_s2_ready;
    assign o_res.red_out   = r_s2_ready ? w_rdata[23:16] : 8'd0;
    assign o_res.green_out = r_s2_ready ? w_rdata[15:8]  : 8'd0;
    assign o_res.blue_out  = r_s2_ready ? w_rdata[7:0]   : 8'd0;
    assign o_res.last_pixel = r_s2_last;

    `IOT_ASSERT_SAME(a_not_ready_zero, o_res_valid && !o_res.ready_res,
        o_res.red_out == 8'd0 && o_res.green_out == 8'd0 && o_res.blue_out == 8'd0 &&
        !o_res.last_pixel, "word without a full frame carries data")
    `IOT_ASSERT_ALWAYS(a_fetch_latency,
        o_res_valid == ($past(w_fetch, 2) && $past(i_rst_n, 1) && $past(i_rst_n, 2)),
        "result strobe does not follow a fetch by two cycles")
    `IOT_ASSERT_SAME(a_restart_addr, w_load && r_frame_complete, w_req.waddr == '0,
        "new frame does not start at pixel zero")

endmodule

// ===== bench/image_orientation_transform_tb.sv =====
// Self-checking testbench for the image orientation transform frame store.
`timescale 1ns / 1ps

module image_orientation_transform_tb;
    import iot_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 70;

    // Tracks the stored frame, the fetch position and the registers, and
    // holds the pixels that fetch words still owe.
    class pixel_scoreboard;
        logic [PIX_W-1:0] frame_mem [DEPTH];
        bit               written [DEPTH];
        int unsigned      loaded;
        bit               full;
        int unsigned      out_row;
        int unsigned      out_col;
        logic [1:0]       mode;
        logic [8:0]       height_reg;
        logic [8:0]       width_reg;
        t_out_word        pending_pixels[$];
        int unsigned      errors;

        function new();
            mode       = MODE_COPY;
            height_reg = 9'd256;
            width_reg  = 9'd256;
        endfunction

        function void set_regs(logic [1:0] m, logic [8:0] h, logic [8:0] w);
            mode       = m;
            height_reg = h;
            width_reg  = w;
        endfunction

        function int unsigned clamp_dim(logic [8:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return 32'(v);
        endfunction

        function int unsigned rows();
            return clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function int unsigned cols();
            return clamp_dim(width_reg, MAX_WIDTH);
        endfunction

        function void out_shape(output int unsigned orows, output int unsigned ocols);
            orows = (mode == MODE_ROT) ? cols() : rows();
            ocols = (mode == MODE_ROT) ? rows() : cols();
        endfunction

        // Source address of the next fetch, after any wrap of the position.
        function int unsigned fetch_addr();
            int unsigned orows, ocols, r, c, sr, sc;
            out_shape(orows, ocols);
            r = out_row;
            c = out_col;
            if (r >= orows || c >= ocols) begin
                r = 0;
                c = 0;
            end
            case (mode)
                MODE_HFLIP: begin
                    sr = r;
                    sc = cols() - 1 - c;
                end
                MODE_VFLIP: begin
                    sr = rows() - 1 - r;
                    sc = c;
                end
                MODE_ROT: begin
                    sr = rows() - 1 - c;
                    sc = r;
                end
                default: begin
                    sr = r;
                    sc = c;
                end
            endcase
            return sr * cols() + sc;
        endfunction

        function bit fetch_reads_unwritten();
            return full && !written[fetch_addr()];
        endfunction

        function void note_word(t_in_word word);
            int unsigned total, orows, ocols, addr;
            t_out_word px;
            total = rows() * cols();
            px = '0;
            if (word.func == FUNC_LOAD) begin
                if (full || loaded >= total) begin
                    loaded  = 0;
                    full    = 1'b0;
                    out_row = 0;
                    out_col = 0;
                end
                if (loaded < DEPTH) begin
                    frame_mem[loaded] = {word.red_in, word.green_in, word.blue_in};
                    written[loaded]   = 1'b1;
                end
                loaded++;
                if (loaded >= total) full = 1'b1;
                return;
            end
            if (full) begin
                out_shape(orows, ocols);
                addr = fetch_addr();
                if (out_row >= orows || out_col >= ocols) begin
                    out_row = 0;
                    out_col = 0;
                end
                px.ready_res = 1'b1;
                {px.red_out, px.green_out, px.blue_out} = frame_mem[addr];
                out_col++;
                if (out_col >= ocols) begin
                    out_col = 0;
                    out_row++;
                    if (out_row >= orows) begin
                        out_row = 0;
                        px.last_pixel = 1'b1;
                    end
                end
            end
            pending_pixels.push_back(px);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_out_word got);
            t_out_word want;
            if (pending_pixels.size() == 0) begin
                $error("result word %h arrived with no fetch pending", got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            compare("ready_res", 8'(want.ready_res), 8'(got.ready_res));
            compare("red_out", want.red_out, got.red_out);
            compare("green_out", want.green_out, got.green_out);
            compare("blue_out", want.blue_out, got.blue_out);
            compare("last_pixel", 8'(want.last_pixel), 8'(got.last_pixel));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_start    = 1'b0;
    t_in_word             i_in       = '0;
    logic                 o_busy;
    logic                 o_res_valid;
    t_out_word            o_res;

    pixel_scoreboard pixels = new();
    int unsigned     idle_pct;
    int unsigned     words_sent;
    int unsigned     quiet_cycles;

    image_orientation_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) pixels.check_pixel(o_res);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_res_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Holds the word until it is taken, then idles at random.
    task automatic send_word(input t_in_word word);
        i_in    <= word;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pixels.note_word(word);
        words_sent++;
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    function automatic t_in_word random_word(logic func);
        t_in_word word;
        word.func = func;
        {word.red_in, word.green_in, word.blue_in} = 24'($urandom);
        return word;
    endfunction

    task automatic load_pixel();
        send_word(random_word(FUNC_LOAD));
    endtask

    // A fetch that would read a store entry never written is left out.
    task automatic fetch_pixel();
        if (!pixels.fetch_reads_unwritten()) send_word(random_word(FUNC_FETCH));
    endtask

    // Waits until every fetch has answered and any load in flight has landed.
    task automatic drain();
        i_start <= 1'b0;
        while (pixels.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [1:0] mode, input logic [8:0] height,
                              input logic [8:0] width);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= CFG_W'(mode);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= height;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= width;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pixels.set_regs(mode, height, width);
    endtask

    // One frame: configure, load it with stray fetches mixed in, read it back, and
    // sometimes reconfigure while it is held and read again; or load part way and fetch.
    task automatic random_frame();
        logic [1:0]  mode;
        logic [8:0]  hraw, wraw;
        int unsigned total;
        mode = 2'($urandom_range(3));
        hraw = 9'($urandom_range(1, 6));
        wraw = 9'($urandom_range(1, 6));
        drain();
        write_regs(mode, hraw, wraw);
        total = pixels.rows() * pixels.cols();
        if ($urandom_range(99) < 10) begin
            // Broken frame: stop after a random count of loads, up to the whole frame, and fetch anyway.
            repeat ($urandom_range(1, total)) load_pixel();
            repeat ($urandom_range(1, 3)) fetch_pixel();
            return;
        end
        do begin
            if ($urandom_range(99) < 8) fetch_pixel();
            load_pixel();
        end while (!pixels.full);
        repeat ($urandom_range(1, 2 * total + 1)) fetch_pixel();
        if ($urandom_range(99) < 30) begin
            drain();
            if ($urandom_range(1)) begin
                hraw = 9'($urandom_range(0, 7));
                wraw = 9'($urandom_range(0, 7));
            end
            write_regs(2'($urandom_range(3)), hraw, wraw);
            repeat ($urandom_range(1, total + 2)) fetch_pixel();
        end
    endtask

    task automatic random_phase(input int unsigned pct);
        int unsigned target;
        idle_pct = pct;
        target = words_sent + PHASE_WORDS;
        while (words_sent < target) random_frame();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 0;

        // Nothing stored yet: fetches answer not ready with zero colour.
        send_word({FUNC_FETCH, 24'hFFFFFF});
        send_word({FUNC_FETCH, 24'h000000});
        // A zero height acts as one row.
        drain();
        write_regs(MODE_COPY, 9'd0, 9'd3);
        send_word({FUNC_LOAD, 24'h000000});
        send_word({FUNC_LOAD, 24'hFFFFFF});
        send_word({FUNC_LOAD, 24'hA5C35A});
        repeat (4) fetch_pixel();
        // Mode changes over the held frame.
        drain();
        write_regs(MODE_HFLIP, 9'd1, 9'd3);
        repeat (3) fetch_pixel();
        drain();
        write_regs(MODE_ROT, 9'd1, 9'd3);
        repeat (3) fetch_pixel();
        // Oversized height saturates, so two loads leave the frame open.
        drain();
        write_regs(MODE_VFLIP, 9'd511, 9'd1);
        load_pixel();
        load_pixel();
        // Shrinking to the count already loaded: the next load restarts.
        drain();
        write_regs(MODE_VFLIP, 9'd2, 9'd1);
        fetch_pixel();
        load_pixel();
        load_pixel();
        repeat (2) fetch_pixel();
        // A load after a complete frame starts a new one.
        load_pixel();
        fetch_pixel();

        // A frame of the largest height, set by an oversized register value,
        // read back as one full rotated image.
        drain();
        write_regs(MODE_ROT, 9'd300, 9'd1);
        do load_pixel(); while (!pixels.full);
        repeat (MAX_HEIGHT) fetch_pixel();

        random_phase(0);
        random_phase(76);
        random_phase(6);
        random_phase(0);

        drain();
        if (pixels.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== image_orientation_transform.f =====
+incdir+design
design/iot_pkg.sv
design/iot_frame_store.sv
design/image_orientation_transform.sv
bench/image_orientation_transform_tb.sv
